>>> rtl/crc_cmb_pkg.sv
`timescale 1ns / 1ps

package crc_cmb_pkg;

    // Number of length bits scanned.
    localparam int LEN_BITS = 32;
    localparam int CNT_W    = $clog2(LEN_BITS + 1);

    // Low word of the field polynomial x^32 + x^7 + x^5 + x^3 + x^2 + x + 1.
    localparam logic [7:0] POLY_LOW = 8'haf;

    localparam int TBL_DEPTH = 32;
    localparam int TBL_IDX_W = 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINAL
    } state_t;

    // Word k is x^(8*2^k) mod P.
    function automatic logic [31:0] pow_word(input logic [TBL_IDX_W-1:0] idx);
        logic [31:0] w;
        unique case (idx)
            5'd0:  w = 32'h00000100;
            5'd1:  w = 32'h00010000;
            5'd2:  w = 32'h000000af;
            5'd3:  w = 32'h00004455;
            5'd4:  w = 32'h10101111;
            5'd5:  w = 32'hae01ae01;
            5'd6:  w = 32'h1bd81099;
            5'd7:  w = 32'h87f2f581;
            5'd8:  w = 32'h9dd170d4;
            5'd9:  w = 32'h5bbedfd6;
            5'd10: w = 32'h27afa5be;
            5'd11: w = 32'hf0db1b29;
            5'd12: w = 32'h2264a683;
            5'd13: w = 32'hfaa007ab;
            5'd14: w = 32'h0a402c54;
            5'd15: w = 32'h2d26e110;
            5'd16: w = 32'hc99cb412;
            5'd17: w = 32'h5e545a7b;
            5'd18: w = 32'h6dc24493;
            5'd19: w = 32'h7dae76c1;
            5'd20: w = 32'hd7a20af5;
            5'd21: w = 32'h978e3ee2;
            5'd22: w = 32'h629ca6e1;
            5'd23: w = 32'h0a831f49;
            5'd24: w = 32'h2802d252;
            5'd25: w = 32'hc6c412e6;
            5'd26: w = 32'h39697bab;
            5'd27: w = 32'h2d222274;
            5'd28: w = 32'h9999aaf2;
            5'd29: w = 32'h00000002;
            5'd30: w = 32'h00000004;
            5'd31: w = 32'h00000010;
            default: w = 32'h00000000;
        endcase
        return w;
    endfunction

endpackage

>>> rtl/crc_cmb_gfmul.sv
`timescale 1ns / 1ps

// Product of two 32-bit polynomials modulo P, one per cycle.
module crc_cmb_gfmul (
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic [31:0] product
);

    logic [63:0] prod_full;
    logic [39:0] fold1;
    logic [15:0] fold2;

    // Carryless 32x32 product: XOR of shifted partial products.
    always_comb begin
        prod_full = '0;
        for (int i = 0; i < 32; i++) begin
            if (op_a[i]) begin
                prod_full = prod_full ^ ({32'h0, op_b} << i);
            end
        end
    end

    // Fold the high word back: x^32 == POLY_LOW.
    always_comb begin
        fold1 = '0;
        for (int j = 0; j < 8; j++) begin
            if (crc_cmb_pkg::POLY_LOW[j]) begin
                fold1 = fold1 ^ ({8'h0, prod_full[63:32]} << j);
            end
        end
    end

    // Second fold covers the few bits that spill past x^31.
    always_comb begin
        fold2 = '0;
        for (int j = 0; j < 8; j++) begin
            if (crc_cmb_pkg::POLY_LOW[j]) begin
                fold2 = fold2 ^ ({8'h0, fold1[39:32]} << j);
            end
        end
    end

    assign product = prod_full[31:0] ^ fold1[31:0] ^ {16'h0, fold2};

endmodule

>>> rtl/crc32_combine_poly_af.sv
`timescale 1ns / 1ps
// Sequence: after the input transfer, one scan step per length bit, LEN_BITS
// in all, then one final multiply that loads the output register once it is free.
// A new item is taken only in idle, after the last one is done, since every
// step of an item goes through the single shared GF(2^32) multiplier.
// Reset: aresetn low at a rising edge returns the sequencer to idle and drops
// any pending result; no stored table or state survives between items.
module crc32_combine_poly_af (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_crc_first,
    input  logic [31:0] s_crc_second,
    input  logic [31:0] s_second_length,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_combined_crc
);

    localparam int CNT_W = crc_cmb_pkg::CNT_W;

    crc_cmb_pkg::state_t state_reg, state_next;

    // Control registers.
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic [crc_cmb_pkg::TBL_IDX_W-1:0] tidx_reg, tidx_next;
    logic                              m_valid_reg, m_valid_next;

    // Payload registers.
    logic [31:0] first_reg, first_next;
    logic [31:0] second_reg, second_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] pow_reg, pow_next;
    logic [31:0] out_reg, out_next;

    // Shared multiplier.
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_p;

    logic out_free;

    crc_cmb_gfmul u_mul (
        .op_a    (mul_a),
        .op_b    (mul_b),
        .product (mul_p)
    );

    assign out_free = !m_valid_reg || m_ready;

    assign s_ready        = (state_reg == crc_cmb_pkg::ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_combined_crc = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= crc_cmb_pkg::ST_IDLE;
            cnt_reg     <= '0;
            tidx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            tidx_reg    <= tidx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_reg  <= first_next;
        second_reg <= second_next;
        len_reg    <= len_next;
        pow_reg    <= pow_next;
        out_reg    <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        tidx_next    = tidx_reg;
        m_valid_next = m_valid_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        len_next     = len_reg;
        pow_next     = pow_reg;
        out_next     = out_reg;

        // Scan steps multiply a table word into the running power; the final
        // step multiplies the power by the inverted first CRC.
        if (state_reg == crc_cmb_pkg::ST_FINAL) begin
            mul_a = pow_reg;
            mul_b = ~first_reg;
        end else begin
            mul_a = crc_cmb_pkg::pow_word(tidx_reg);
            mul_b = pow_reg;
        end

        // Drop the result once the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            crc_cmb_pkg::ST_IDLE: begin
                if (s_valid) begin
                    first_next  = s_crc_first;
                    second_next = s_crc_second;
                    len_next    = s_second_length;
                    pow_next    = 32'h00000001;
                    cnt_next    = CNT_W'(crc_cmb_pkg::LEN_BITS - 1);
                    tidx_next   = '0;
                    state_next  = crc_cmb_pkg::ST_SCAN;
                end
            end
            crc_cmb_pkg::ST_SCAN: begin
                // Fold in the table word only for set length bits.
                if (len_reg[0]) begin
                    pow_next = mul_p;
                end
                // Advance to the next length bit; the table index wraps.
                len_next  = {1'b0, len_reg[31:1]};
                tidx_next = tidx_reg + 1'b1;
                if (cnt_reg == '0) begin
                    state_next = crc_cmb_pkg::ST_FINAL;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            crc_cmb_pkg::ST_FINAL: begin
                // Hold until the output register is free.
                if (out_free) begin
                    out_next     = mul_p ^ second_reg;
                    m_valid_next = 1'b1;
                    state_next   = crc_cmb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = crc_cmb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
